// ===== rtl/core/stbt_pkg.sv =====
// Shared constants, types and index tables for the symmetric tensor basis transform.
// Used by every module under rtl/core but stbt_checker; depends on nothing else.
package stbt_pkg;

  // Component format default (signed Q(W-16).16).
  localparam int COMP_WIDTH_DEF = 32;
  localparam int NUM_COMP       = 6;

  // Matrix entries are signed Q3.17, three to a 63-bit row register.
  localparam int ENTRY_W = 21;
  localparam int ROW_W   = 63;

  // Coefficient A[k][m]*A[l][n] (+ mirrored term) is Q.34 in 43 signed bits.
  // It is split into a signed high part and an unsigned low part of CL_W bits.
  localparam int COEF_W = 43;
  localparam int CL_W   = 22;

  // Accumulator carries 34 fraction bits plus guard bits above the component.
  localparam int FRAC_SHIFT = 34;
  localparam int ACC_GUARD  = 46;

  // Result queue and the number of register stages in a lane.
  localparam int QUEUE_DEPTH = 8;
  localparam int PIPE_DEPTH  = 4;

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW0 = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW1 = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW2 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_MODE = CFG_INDEX_W'(3);

  // Identity matrix at reset.
  localparam logic [ROW_W-1:0] ROW0_RST = 63'd131072;
  localparam logic [ROW_W-1:0] ROW1_RST = 63'd274877906944;
  localparam logic [ROW_W-1:0] ROW2_RST = 63'd576460752303423488;

  // Upper-triangle order of the tensor components: xx, xy, xz, yy, yz, zz.
  localparam int TRI_K [NUM_COMP] = '{0, 0, 0, 1, 1, 2};
  localparam int TRI_L [NUM_COMP] = '{0, 1, 2, 1, 2, 2};

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef entry_t [2:0][2:0] matrix_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

// ===== rtl/core/symmetric_tensor_basis_transform.sv =====
// Symmetric 3x3 tensor basis transform: top level with configuration registers,
// six component lanes, the merging stage and the result queue.
// Depends on stbt_pkg, stbt_lane, stbt_merge and stbt_outq.
//
// Usage: each item on the s_ channel carries the six upper-triangle components
// of a symmetric tensor; the m_ channel returns the six transformed components
// in tdata and the clip flag in tuser. The cfg channel writes the three matrix
// rows (index 0..2) and the mode bit (index 3); cfg_ready is always high. The user
// must make writes only while no item is in flight; the block does not enforce it.
// A result is offered once its item has passed the lane pipeline (input register,
// multiplier stage, two adder stages) and the queue write. One item is taken per
// cycle while s_tready is high; the lane pipeline itself never stalls.
// Up to 8 items may be accepted and not yet delivered; when the receiver stalls
// results collect in the 8-entry queue and s_tready drops once 8 items are
// outstanding, which may be before the queue itself has filled.
// Reset loads the identity matrix and covariant mode and empties the pipeline
// and the queue; s_tready is low while rst is high.
module symmetric_tensor_basis_transform import stbt_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  localparam int DATA_W = ((NUM_COMP * COMP_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [DATA_W-1:0]      s_tdata,   // in_xx, in_xy, in_xz, in_yy, in_yz, in_zz
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [DATA_W-1:0]      m_tdata,   // out_xx, out_xy, out_xz, out_yy, out_yz, out_zz
  output logic                   m_tuser,   // saturated
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ACC_W  = COMP_WIDTH + ACC_GUARD;
  localparam int PAY_W  = NUM_COMP * COMP_WIDTH;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_M [NUM_COMP] = '{0, 0, 0, 1, 1, 2};
  localparam int OUT_N [NUM_COMP] = '{0, 1, 2, 1, 2, 2};

  logic [2:0][ROW_W-1:0]   matrix_rows;
  logic                    contravariant_mode;
  matrix_t                 m_mat;
  matrix_t                 a_mat;
  logic                    s_accept;
  logic [PIPE_DEPTH-1:0]   stage_valid;
  logic [CNT_W-1:0]        inflight;
  logic [CNT_W-1:0]        inflight_next;
  logic signed [ACC_W-1:0] lane_acc [NUM_COMP];
  logic [PAY_W-1:0]        merged;
  logic                    merged_sat;
  logic [PAY_W:0]          q_data;
  q_ctrl_t                 q_ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_rows[0]     <= ROW0_RST;
      matrix_rows[1]     <= ROW1_RST;
      matrix_rows[2]     <= ROW2_RST;
      contravariant_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0: matrix_rows[0] <= cfg_data[ROW_W-1:0];
        REG_ROW1: matrix_rows[1] <= cfg_data[ROW_W-1:0];
        REG_ROW2: matrix_rows[2] <= cfg_data[ROW_W-1:0];
        REG_MODE: contravariant_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Contravariant mode uses the transpose, so every lane sees the same form
  // sum over k,l of A[k][m] * A[l][n] * T[k][l].
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_mat[r][c] = matrix_rows[r][ENTRY_W*c +: ENTRY_W];
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        a_mat[r][c] = contravariant_mode ? m_mat[c][r] : m_mat[r][c];
      end
    end
  end

  assign s_tready = !rst && (inflight < CNT_W'(QUEUE_DEPTH));
  assign s_accept = s_tvalid && s_tready;

  for (genvar i = 0; i < NUM_COMP; i++) begin : g_lane
    stbt_lane #(
      .COMP_WIDTH (COMP_WIDTH),
      .M_IDX      (OUT_M[i]),
      .N_IDX      (OUT_N[i])
    ) u_lane (
      .clk    (clk),
      .load   (s_accept),
      .matrix (a_mat),
      .tensor (s_tdata[PAY_W-1:0]),
      .acc    (lane_acc[i])
    );
  end

  stbt_merge #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_merge (
    .acc       (lane_acc),
    .comps     (merged),
    .saturated (merged_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      inflight    <= '0;
    end else begin
      stage_valid <= {stage_valid[PIPE_DEPTH-2:0], s_accept};
      inflight    <= inflight_next;
    end
  end

  assign q_ctrl.push   = stage_valid[PIPE_DEPTH-1];
  assign q_ctrl.pop    = m_tvalid && m_tready;
  assign inflight_next = inflight + CNT_W'(s_accept) - CNT_W'(q_ctrl.pop);

  stbt_outq #(
    .WIDTH (PAY_W + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (q_ctrl),
    .push_data ({merged_sat, merged}),
    .valid     (m_tvalid),
    .data      (q_data)
  );

  assign m_tdata = DATA_W'(q_data[PAY_W-1:0]);
  assign m_tuser = q_data[PAY_W];

endmodule

// ===== rtl/core/stbt_lane.sv =====
// One output component lane: coefficient products, tensor products and accumulation.
// Depends on stbt_pkg.
module stbt_lane import stbt_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int M_IDX = 0,
  parameter int N_IDX = 0,
  localparam int ACC_W = COMP_WIDTH + ACC_GUARD
) (
  input  logic                           clk,
  input  logic                           load,
  input  matrix_t                        matrix,
  input  logic [NUM_COMP*COMP_WIDTH-1:0] tensor,
  output logic signed [ACC_W-1:0]        acc
);

  localparam int CH_W = COEF_W - CL_W;
  localparam int PH_W = CH_W + COMP_WIDTH;
  localparam int PL_W = CL_W + 1 + COMP_WIDTH;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

  logic signed [COEF_W-1:0]     coef [NUM_COMP];
  logic signed [COMP_WIDTH-1:0] comp [NUM_COMP];
  logic signed [PH_W-1:0]       ph   [NUM_COMP];
  logic signed [PL_W-1:0]       pl   [NUM_COMP];
  logic signed [ACC_W-1:0]      term [NUM_COMP];
  logic signed [ACC_W-1:0]      pair [NUM_COMP/2];

  // The coefficients follow the configuration every cycle; the user must change the
  // matrix only while no item is in flight, which the block does not enforce.
  for (genvar i = 0; i < NUM_COMP; i++) begin : g_coef
    localparam int K = TRI_K[i];
    localparam int L = TRI_L[i];
    logic signed [2*ENTRY_W-1:0] prod_a;
    logic signed [2*ENTRY_W-1:0] prod_b;

    assign prod_a = $signed(matrix[K][M_IDX]) * $signed(matrix[L][N_IDX]);
    if (K == L) begin : g_diag
      assign prod_b = '0;
    end else begin : g_off
      // Off-diagonal components appear twice in the full tensor.
      assign prod_b = $signed(matrix[L][M_IDX]) * $signed(matrix[K][N_IDX]);
    end

    always_ff @(posedge clk) begin
      coef[i] <= COEF_W'(prod_a) + COEF_W'(prod_b);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        comp[i] <= $signed(tensor[i*COMP_WIDTH +: COMP_WIDTH]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_COMP; i++) begin
      ph[i] <= $signed(coef[i][COEF_W-1:CL_W]) * comp[i];
      pl[i] <= $signed({1'b0, coef[i][CL_W-1:0]}) * comp[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      term[i] = (ACC_W'(ph[i]) <<< CL_W) + ACC_W'(pl[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_COMP/2; j++) begin
      pair[j] <= term[2*j] + term[2*j+1];
    end
    acc <= pair[0] + pair[1] + pair[2] + HALF;
  end

endmodule

// ===== rtl/core/stbt_merge.sv =====
// Merging stage: saturates the six rounded lane sums and combines their clip flags.
// Depends on stbt_pkg.
module stbt_merge import stbt_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  localparam int ACC_W = COMP_WIDTH + ACC_GUARD
) (
  input  logic signed [ACC_W-1:0]        acc [NUM_COMP],
  output logic [NUM_COMP*COMP_WIDTH-1:0] comps,
  output logic                           saturated
);

  // Bits from the result's sign bit up that must all agree for the value to fit.
  localparam int HI_W = ACC_W - FRAC_SHIFT - COMP_WIDTH + 1;
  localparam logic [COMP_WIDTH-1:0] COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam logic [COMP_WIDTH-1:0] COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  always_comb begin
    logic [HI_W-1:0] upper;
    comps     = '0;
    saturated = 1'b0;
    upper     = '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      upper = acc[i][ACC_W-1:FRAC_SHIFT+COMP_WIDTH-1];
      if (upper == '0 || upper == '1) begin
        comps[i*COMP_WIDTH +: COMP_WIDTH] = acc[i][FRAC_SHIFT+COMP_WIDTH-1:FRAC_SHIFT];
      end else begin
        saturated = 1'b1;
        comps[i*COMP_WIDTH +: COMP_WIDTH] = acc[i][ACC_W-1] ? COMP_MIN : COMP_MAX;
      end
    end
  end

endmodule

// ===== rtl/core/stbt_outq.sv =====
// Result queue that holds finished items until the receiver takes them.
// Depends on stbt_pkg for the control struct and the default depth.
module stbt_outq import stbt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  q_ctrl_t          ctrl,
  input  logic [WIDTH-1:0] push_data,
  output logic             valid,
  output logic [WIDTH-1:0] data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign count_next = count + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (ctrl.pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

endmodule

// ===== rtl/core/stbt_checker.sv =====
// Port-level checks for the symmetric tensor basis transform, bound to the top level.
// Depends only on the top level's ports.
module stbt_checker #(
  parameter int DATA_W = 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic              m_tuser
);

  // Reset empties the pipeline and the result queue.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // A result first appears exactly after the pipeline latency of an accepted item.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
    else $error("result appeared without an item accepted five cycles before");

  // Input side closes only when the last accept filled the in-flight budget.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(s_tvalid && s_tready))
    else $error("s_tready dropped without an accepted item");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind symmetric_tensor_basis_transform stbt_checker #(
  .DATA_W (DATA_W)
) u_stbt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== sim/symmetric_tensor_basis_transform_test.sv =====
// Self-checking bench for symmetric_tensor_basis_transform: streams tensors under random
// back-pressure and compares every result with a bit-exact congruence-transform predictor.
// Depends on stbt_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module symmetric_tensor_basis_transform_test;
  import stbt_pkg::*;

  localparam int COMP_W = COMP_WIDTH_DEF;
  localparam int DATA_W = NUM_COMP * COMP_W;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_TOP   = '1;

  localparam logic [ENTRY_W-1:0] ENTRY_MAX  = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic [ENTRY_W-1:0] ENTRY_MIN  = {1'b1, {(ENTRY_W-1){1'b0}}};
  localparam logic [ENTRY_W-1:0] ENTRY_ONE  = ENTRY_W'(1 << 17);
  localparam logic [ENTRY_W-1:0] ENTRY_HALF = ENTRY_W'(1 << 16);

  localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (FRAC_SHIFT - 1);
  localparam logic signed [127:0] SUM_MAX    = (128'sd1 <<< (COMP_W - 1)) - 128'sd1;
  localparam logic signed [127:0] SUM_MIN    = -(128'sd1 <<< (COMP_W - 1));

  localparam int SYM_POS [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

  typedef enum logic {COVARIANT = 1'b0, CONTRAVARIANT = 1'b1} basis_mode_t;
  typedef logic signed [COMP_W-1:0] comp_t;
  typedef comp_t [NUM_COMP-1:0] tensor_t;
  typedef struct packed {
    logic    sat;
    tensor_t comp;
  } result_t;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [DATA_W-1:0]      m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  symmetric_tensor_basis_transform dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Local copy of the configuration registers.
  logic [ROW_W-1:0] basis_rows [3] = '{ROW0_RST, ROW1_RST, ROW2_RST};
  basis_mode_t      basis_mode = COVARIANT;

  tensor_t pending_tensors [$];
  result_t expected_results [$];
  int      queued_count = 0;
  int      accepted_count = 0;
  int      mismatch_count = 0;
  bit      item_taken = 1'b0;
  int      send_wait = 0;
  int      recv_wait = 0;
  bit      send_style = 1'b0;
  bit      recv_style = 1'b0;
  string   comp_name [NUM_COMP] = '{"xx", "xy", "xz", "yy", "yz", "zz"};

  function automatic entry_t matrix_entry(int r, int c);
    return entry_t'(basis_rows[r][ENTRY_W*c +: ENTRY_W]);
  endfunction

  // Every term is exact in 128 bits; the sum is rounded half up and clamped.
  function automatic result_t transform_tensor(tensor_t t);
    result_t r;
    logic signed [127:0] sum, ea, eb, tv;
    int m, n;
    r.sat = 1'b0;
    for (int i = 0; i < NUM_COMP; i++) begin
      m = TRI_K[i];
      n = TRI_L[i];
      sum = '0;
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          if (basis_mode == CONTRAVARIANT) begin
            ea = matrix_entry(m, k);
            eb = matrix_entry(n, l);
          end else begin
            ea = matrix_entry(k, m);
            eb = matrix_entry(l, n);
          end
          tv = t[SYM_POS[k][l]];
          sum = sum + ea * eb * tv;
        end
      end
      sum = (sum + ROUND_HALF) >>> FRAC_SHIFT;
      if (sum > SUM_MAX) begin
        r.comp[i] = COMP_MAX;
        r.sat = 1'b1;
      end else if (sum < SUM_MIN) begin
        r.comp[i] = COMP_MIN;
        r.sat = 1'b1;
      end else begin
        r.comp[i] = sum[COMP_W-1:0];
      end
    end
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap(bit style);
    int roll;
    roll = $urandom_range(0, 99);
    if (!style || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_row(logic [ENTRY_W-1:0] e0, e1, e2,
                                                      logic spare);
    return {spare, e2, e1, e0};
  endfunction

  function automatic logic [ENTRY_W-1:0] draw_entry();
    int v;
    case ($urandom_range(0, 9))
      0: return ENTRY_MAX;
      1: return ENTRY_MIN;
      2, 3: return ENTRY_W'($urandom);
      default: begin
        v = int'($urandom_range(0, 2 * (1 << 17))) - (1 << 17);
        return ENTRY_W'(v);
      end
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_row();
    return pack_row(draw_entry(), draw_entry(), draw_entry(), 1'($urandom));
  endfunction

  // Components mix full-range words, extremes and values of random magnitude.
  function automatic tensor_t draw_tensor();
    tensor_t t;
    for (int i = 0; i < NUM_COMP; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 4))
            0: t[i] = COMP_MAX;
            1: t[i] = COMP_MIN;
            2: t[i] = '0;
            3: t[i] = comp_t'(1);
            default: t[i] = comp_t'(-1);
          endcase
        end
        1, 2, 3: t[i] = comp_t'($urandom);
        default: t[i] = comp_t'(signed'($urandom) >>> $urandom_range(8, 31));
      endcase
    end
    return t;
  endfunction

  task automatic push_tensor(tensor_t t);
    pending_tensors.push_back(t);
    queued_count++;
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (accepted_count != queued_count || expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic note_mismatch(string what, logic [COMP_W-1:0] want, logic [COMP_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Register writes and accepted items are captured here, so the prediction
  // always uses the configuration that the block holds.
  always @(posedge clk) begin
    if (rst) begin
      basis_rows[0] = ROW0_RST;
      basis_rows[1] = ROW1_RST;
      basis_rows[2] = ROW2_RST;
      basis_mode = COVARIANT;
      item_taken = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW0: basis_rows[0] = cfg_data[ROW_W-1:0];
          REG_ROW1: basis_rows[1] = cfg_data[ROW_W-1:0];
          REG_ROW2: basis_rows[2] = cfg_data[ROW_W-1:0];
          REG_MODE: basis_mode = basis_mode_t'(cfg_data[0]);
          default: ;
        endcase
      end
      item_taken = s_tvalid && s_tready;
      if (item_taken) begin
        expected_results.push_back(transform_tensor(tensor_t'(s_tdata)));
        accepted_count++;
      end
    end
  end

  // Sender: a new item goes out only once the previous one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      if (send_wait > 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_tensors.size() > 0) begin
        s_tdata <= pending_tensors.pop_front();
        s_tvalid <= 1'b1;
        send_wait = pick_gap(send_style);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      recv_wait = pick_gap(recv_style);
    end
  end

  always @(posedge clk) begin
    result_t want;
    tensor_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = tensor_t'(m_tdata);
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result %h arrived with no tensor outstanding", $realtime, m_tdata);
      end else begin
        want = expected_results.pop_front();
        for (int i = 0; i < NUM_COMP; i++)
          if (got[i] !== want.comp[i])
            note_mismatch({"out_", comp_name[i]}, want.comp[i], got[i]);
        if (m_tuser !== want.sat)
          note_mismatch("saturated", COMP_W'(want.sat), COMP_W'(m_tuser));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Identity matrix from reset: components pass through unchanged.
    push_tensor('0);
    push_tensor({NUM_COMP{COMP_MAX}});
    push_tensor({NUM_COMP{COMP_MIN}});
    push_tensor({COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX});
    push_tensor({NUM_COMP{comp_t'(-1)}});
    drain_results();

    // Diagonal of one half: each sum lands exactly on a rounding tie.
    write_register(REG_ROW0, pack_row(ENTRY_HALF, '0, '0, 1'b0));
    write_register(REG_ROW1, pack_row('0, ENTRY_HALF, '0, 1'b0));
    write_register(REG_ROW2, pack_row('0, '0, ENTRY_HALF, 1'b1));
    push_tensor({NUM_COMP{comp_t'(2)}});
    push_tensor({NUM_COMP{comp_t'(-2)}});
    push_tensor({NUM_COMP{comp_t'(6)}});
    push_tensor({NUM_COMP{comp_t'(-6)}});
    drain_results();

    // Largest entries drive the sums past both bounds; the top data bit is ignored.
    write_register(REG_ROW0, pack_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, 1'b1));
    write_register(REG_ROW1, pack_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, 1'b1));
    write_register(REG_ROW2, pack_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, 1'b1));
    push_tensor({NUM_COMP{COMP_MAX}});
    push_tensor({NUM_COMP{COMP_MIN}});
    push_tensor({COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX});
    drain_results();
    write_register(REG_MODE, CFG_DATA_W'(CONTRAVARIANT));
    write_register(REG_ROW0, pack_row(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN, 1'b0));
    write_register(REG_ROW1, pack_row(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN, 1'b0));
    write_register(REG_ROW2, pack_row(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN, 1'b0));
    push_tensor({NUM_COMP{COMP_MAX}});
    push_tensor({NUM_COMP{COMP_MIN}});
    drain_results();

    // A singular, non-symmetric matrix in both modes; mode writes carry junk upper bits.
    write_register(REG_ROW0, draw_row());
    write_register(REG_ROW1, draw_row());
    write_register(REG_ROW2, '0);
    write_register(REG_MODE, '1);
    push_tensor(draw_tensor());
    push_tensor(draw_tensor());
    drain_results();
    write_register(REG_MODE, ~CFG_DATA_W'(CONTRAVARIANT));
    push_tensor(draw_tensor());
    push_tensor(draw_tensor());
    drain_results();
    write_register(REG_SPARE, {$urandom, $urandom});
    write_register(REG_TOP, {$urandom, $urandom});
    push_tensor(draw_tensor());
    push_tensor(draw_tensor());
    drain_results();

    // Random part: new matrix and mode per batch, varied back-pressure.
    for (int batch = 0; batch < 8; batch++) begin
      send_style = (batch != 0) && (batch % 4 != 3);
      recv_style = (batch != 0) && (batch % 4 != 2);
      write_register(REG_ROW0, (batch == 4) ? pack_row(ENTRY_ONE, '0, '0, 1'b0) : draw_row());
      write_register(REG_ROW1, draw_row());
      write_register(REG_ROW2, draw_row());
      write_register(REG_MODE, CFG_DATA_W'(batch % 2) | (CFG_DATA_W'($urandom) << 1));
      for (int i = 0; i < 119; i++)
        push_tensor(draw_tensor());
      // The sender stops here until every result of the batch is back.
      drain_results();
    end

    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
